// ===== design/shl_pkg.sv =====
// Shared types, widths and codes for the sphere highlight light direction block.
// No dependencies; every other file of the block imports this package.

package shl_pkg;

   // Field widths
   localparam int PixW     = 8;              // pixel value
   localparam int PosW     = 10;             // row or column
   localparam int IdxW     = 2;              // image index
   localparam int DirW     = 17;             // signed direction component
   localparam int CsrDataW = 32;
   localparam int NumRegs  = 3;
   localparam int CsrAddrW = $clog2(NumRegs * 4);

   // Frame geometry and image count
   localparam int MaxDim       = 1024;       // positions at or beyond are not tracked
   localparam int NumImagesDef = 3;
   localparam int MaxEmit      = 3;          // images that have a pixel field

   // Datapath widths
   localparam int VaxW   = PixW + PosW;      // value times offset
   localparam int ProdW  = 2 * VaxW;         // squared scaled offset
   localparam int Z2W    = 2 * PosW;         // r^2 and r^2 - d2
   localparam int M2W    = 2 * PosW + 1;     // d2 or r^2
   localparam int FracSh = 16;               // 8 fractional bits, squared
   localparam int NumW   = ProdW + FracSh;   // dividend
   localparam int QW     = 32;               // quotient never exceeds (255*256)^2
   localparam int RootW  = QW / 2;

   // Register map
   typedef enum logic [1:0] {
      REG_CENTER_COL    = 2'd0,
      REG_CENTER_ROW    = 2'd1,
      REG_SPHERE_RADIUS = 2'd2
   } shl_reg_type;

   // Direction component in progress
   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2
   } shl_comp_type;

   // Result sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_PREP4,
      ST_PREP5,
      ST_LAUNCH,
      ST_DIV,
      ST_SQRT,
      ST_EMIT
   } shl_state_type;

   typedef struct packed {
      logic [PosW-1:0] center_col;
      logic [PosW-1:0] center_row;
      logic [PosW-1:0] sphere_radius;
   } shl_cfg_type;

   typedef struct packed {
      logic [PixW-1:0] value;
      logic [PosW-1:0] row;
      logic [PosW-1:0] col;
   } shl_best_type;

endpackage

// ===== design/shl_req_if.sv =====
// Pixel channel: valid/ready handshake carrying one raster position of all images.
// Depends on shl_pkg for field widths.

interface shl_req_if
   import shl_pkg::*;
   ();

   logic            valid;
   logic            ready;
   logic [PixW-1:0] pixel_a;
   logic [PixW-1:0] pixel_b;
   logic [PixW-1:0] pixel_c;
   logic [PosW-1:0] pix_row;
   logic [PosW-1:0] pix_col;
   logic            frame_end;

   modport source (
      output valid, pixel_a, pixel_b, pixel_c, pix_row, pix_col, frame_end,
      input  ready
   );

   modport sink (
      input  valid, pixel_a, pixel_b, pixel_c, pix_row, pix_col, frame_end,
      output ready
   );

endinterface

// ===== design/shl_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one light direction per image.
// Depends on shl_pkg for field widths.

interface shl_rsp_if
   import shl_pkg::*;
   ();

   logic                   valid;
   logic                   ready;
   logic [IdxW-1:0]        image_index;
   logic signed [DirW-1:0] dir_x;
   logic signed [DirW-1:0] dir_y;
   logic signed [DirW-1:0] dir_z;
   logic                   outside_sphere;
   logic                   run_last;

   modport source (
      output valid, image_index, dir_x, dir_y, dir_z, outside_sphere, run_last,
      input  ready
   );

   modport sink (
      input  valid, image_index, dir_x, dir_y, dir_z, outside_sphere, run_last,
      output ready
   );

endinterface

// ===== design/shl_csr.sv =====
// APB-style register file for sphere centre and radius.
// Depends on shl_pkg for the register map and configuration struct.

module shl_csr
   import shl_pkg::*;
   (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready,
   output shl_cfg_type         cfg
   );

   shl_cfg_type     cfg_ff, cfg_in;
   logic [1:0]      reg_idx;
   logic            wr_en;

   assign reg_idx    = csr_paddr[CsrAddrW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CENTER_COL:    cfg_in.center_col    = csr_pwdata[PosW-1:0];
            REG_CENTER_ROW:    cfg_in.center_row    = csr_pwdata[PosW-1:0];
            REG_SPHERE_RADIUS: cfg_in.sphere_radius = csr_pwdata[PosW-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_CENTER_COL:    csr_prdata = {{(CsrDataW-PosW){1'b0}}, cfg_ff.center_col};
         REG_CENTER_ROW:    csr_prdata = {{(CsrDataW-PosW){1'b0}}, cfg_ff.center_row};
         REG_SPHERE_RADIUS: csr_prdata = {{(CsrDataW-PosW){1'b0}}, cfg_ff.sphere_radius};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// ===== design/shl_lane.sv =====
// One brightness tracker lane: keeps the first brightest pixel of one image.
// Depends on shl_pkg for the tracker struct.

module shl_lane
   import shl_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            update,
   input  logic            clear,
   input  logic [PixW-1:0] pixel,
   input  logic [PosW-1:0] row,
   input  logic [PosW-1:0] col,
   output shl_best_type    best
   );

   shl_best_type best_ff, best_in;

   assign best = best_ff;

   // Replace only on a strictly brighter pixel; drop everything at frame close
   always_comb begin
      best_in = best_ff;
      if (clear) begin
         best_in = '0;
      end else if (update && (pixel > best_ff.value)) begin
         best_in.value = pixel;
         best_in.row   = row;
         best_in.col   = col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

endmodule

// ===== design/shl_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on shl_pkg for operand widths.

module shl_div
   import shl_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NumW-1:0] dividend,
   input  logic [M2W-1:0]  divisor,
   output logic            done,
   output logic [QW-1:0]   quotient
   );

   localparam int CntW = $clog2(NumW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [M2W-1:0]  rem_ff, rem_in;
   logic [NumW-1:0] quo_ff, quo_in;
   logic [M2W-1:0]  dsr_ff, dsr_in;
   logic [M2W:0]    shifted;
   logic [M2W:0]    diff;
   logic            ge;

   // Bring down the next dividend bit and try the subtraction
   assign shifted = {rem_ff, quo_ff[NumW-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = shifted >= {1'b0, dsr_ff};

   assign done     = done_ff;
   assign quotient = quo_ff[QW-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(NumW - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[M2W-1:0] : shifted[M2W-1:0];
         quo_in = {quo_ff[NumW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== design/shl_isqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle, floor result.
// Depends on shl_pkg for operand widths.

module shl_isqrt
   import shl_pkg::*;
   (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QW-1:0]    radicand,
   output logic             done,
   output logic [RootW-1:0] root
   );

   localparam int CntW = $clog2(RootW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [QW-1:0]    rad_ff, rad_in;
   logic [RootW-1:0] root_ff, root_in;
   logic [RootW:0]   rem_ff, rem_in;
   logic [RootW+2:0] rem_sh;
   logic [RootW+2:0] trial;
   logic [RootW+2:0] diff;
   logic             ge;

   // Bring down two radicand bits and test root*4+1
   assign rem_sh = {rem_ff, rad_ff[QW-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign ge     = rem_sh >= trial;

   assign done = done_ff;
   assign root = root_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(RootW - 1);
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[RootW:0] : rem_sh[RootW:0];
         root_in = {root_ff[RootW-2:0], ge};
         rad_in  = {rad_ff[QW-3:0], 2'b00};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

endmodule

// ===== design/sphere_highlight_light_direction.sv =====
// Light direction from the highlight on a specular sphere: top level.
// Depends on shl_pkg, shl_req_if, shl_rsp_if, shl_csr, shl_lane, shl_div, shl_isqrt.
//
// Usage
//   req_ch carries one raster position of up to three images per transfer
//   (pixel_a/b/c, pix_row, pix_col, frame_end). Each image has its own tracker
//   lane that keeps the first brightest pixel. Pixels are taken one per cycle
//   while idle. A transfer with frame_end set closes the frame: req_ch.ready
//   drops and a shared sequencer works through the lanes, image 0 first,
//   emitting one rsp_ch transfer per image; run_last marks the final one.
//   Per image: the ST_PREP setup states form squares and products, then for
//   each of x, y and z a serial divide (one quotient bit per cycle) and a
//   serial square root; both are skipped when the magnitude is zero.
//   The divider takes the largest share of the time per image.
//   Results sit in an output register; while the receiver stalls the
//   sequencer holds the next result and the trackers, and pixel input stays
//   closed until the last result of the frame is loaded into that register.
//   Reset (synchronous) clears the trackers, the centre and radius registers
//   and any pending result. Centre and radius are written through the csr_
//   port; the user must write them between frames, the block does not enforce it.

module sphere_highlight_light_direction
   import shl_pkg::*;
   #(
   parameter int NUM_IMAGES = NumImagesDef
   )
   (
   input  logic                clock,
   input  logic                reset,
   shl_req_if.sink             req_ch,
   shl_rsp_if.source           rsp_ch,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
   );

   localparam int NumLanes = (NUM_IMAGES < MaxEmit) ? NUM_IMAGES : MaxEmit;

   shl_cfg_type     cfg;
   shl_best_type    best [NumLanes];
   shl_best_type    sel;
   logic [PixW-1:0] lane_pix [MaxEmit];
   logic            req_fire;
   logic            in_range;
   logic            track;
   logic            clear_trk;

   shl_state_type   state_ff, state_in;
   logic [IdxW-1:0] lane_ff, lane_in;
   shl_comp_type    comp_ff, comp_in;
   logic            div_start;
   logic            sqrt_start;
   logic            emit_load;
   logic            last_lane;
   logic            slot_free;
   logic            div_done;
   logic            sqrt_done;
   logic [QW-1:0]   div_quo;
   logic [RootW-1:0] sqrt_root;
   logic [NumW-1:0] dividend;

   // Per-image working registers
   logic [PixW-1:0]  v_ff;
   logic [PosW-1:0]  ax_ff, ay_ff;
   logic             negx_ff, negy_ff;
   logic [Z2W-1:0]   ax2_ff, ay2_ff, r2_ff, z2_ff;
   logic [VaxW-1:0]  vax_ff, vay_ff;
   logic [2*PixW-1:0] vv_ff;
   logic [M2W-1:0]   d2_ff, m2_ff;
   logic [ProdW-1:0] nx2_ff, ny2_ff, nz2_ff;
   logic             outside_ff;
   logic [RootW-1:0] qx_ff, qy_ff, qz_ff;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IdxW-1:0]        rsp_index_ff;
   logic signed [DirW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                   rsp_outside_ff;
   logic                   rsp_last_ff;
   logic signed [DirW-1:0] mag_x, mag_y, mag_z;

   shl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Accept pixels only while no frame is being closed
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_range     = (int'(req_ch.pix_row) < MaxDim) && (int'(req_ch.pix_col) < MaxDim);
   assign track        = req_fire && in_range;
   assign last_lane    = (lane_ff == IdxW'(NumLanes - 1));
   assign clear_trk    = emit_load && last_lane;

   assign lane_pix[0] = req_ch.pixel_a;
   assign lane_pix[1] = req_ch.pixel_b;
   assign lane_pix[2] = req_ch.pixel_c;

   // Tracker lanes, one per image
   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      shl_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .update (track),
         .clear  (clear_trk),
         .pixel  (lane_pix[i]),
         .row    (req_ch.pix_row),
         .col    (req_ch.pix_col),
         .best   (best[i])
      );
   end

   // Merge: pick the lane being reported
   always_comb begin
      sel = '0;
      for (int i = 0; i < NumLanes; i++) begin
         if (lane_ff == IdxW'(i)) begin
            sel = best[i];
         end
      end
   end

   // Dividend for the component in progress
   always_comb begin
      case (comp_ff)
         COMP_X:  dividend = {nx2_ff, {FracSh{1'b0}}};
         COMP_Y:  dividend = {ny2_ff, {FracSh{1'b0}}};
         default: dividend = {nz2_ff, {FracSh{1'b0}}};
      endcase
   end

   shl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (m2_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   shl_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quo),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer: next state and strobes
   always_comb begin
      state_in   = state_ff;
      lane_in    = lane_ff;
      comp_in    = comp_ff;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      emit_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.frame_end) begin
               state_in = ST_PREP1;
               lane_in  = '0;
            end
         end
         ST_PREP1: state_in = ST_PREP2;
         ST_PREP2: state_in = ST_PREP3;
         ST_PREP3: state_in = ST_PREP4;
         ST_PREP4: state_in = ST_PREP5;
         ST_PREP5: begin
            comp_in = COMP_X;
            if (m2_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               case (comp_ff)
                  COMP_X: begin
                     comp_in  = COMP_Y;
                     state_in = ST_LAUNCH;
                  end
                  COMP_Y: begin
                     comp_in  = COMP_Z;
                     state_in = ST_LAUNCH;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               emit_load = 1'b1;
               if (last_lane) begin
                  state_in = ST_IDLE;
               end else begin
                  lane_in  = lane_ff + 1'b1;
                  state_in = ST_PREP1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lane_ff  <= '0;
         comp_ff  <= COMP_X;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         comp_ff  <= comp_in;
      end
   end

   // Setup pipeline: offsets, squares, magnitude and the three numerators
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_PREP1: begin
            v_ff    <= sel.value;
            negx_ff <= sel.col < cfg.center_col;
            negy_ff <= sel.row < cfg.center_row;
            ax_ff   <= (sel.col < cfg.center_col) ? cfg.center_col - sel.col
                                                  : sel.col - cfg.center_col;
            ay_ff   <= (sel.row < cfg.center_row) ? cfg.center_row - sel.row
                                                  : sel.row - cfg.center_row;
         end
         ST_PREP2: begin
            ax2_ff <= Z2W'(ax_ff) * Z2W'(ax_ff);
            ay2_ff <= Z2W'(ay_ff) * Z2W'(ay_ff);
            vax_ff <= VaxW'(v_ff) * VaxW'(ax_ff);
            vay_ff <= VaxW'(v_ff) * VaxW'(ay_ff);
            vv_ff  <= (2*PixW)'(v_ff) * (2*PixW)'(v_ff);
            r2_ff  <= Z2W'(cfg.sphere_radius) * Z2W'(cfg.sphere_radius);
         end
         ST_PREP3: begin
            d2_ff  <= {1'b0, ax2_ff} + {1'b0, ay2_ff};
            nx2_ff <= ProdW'(vax_ff) * ProdW'(vax_ff);
            ny2_ff <= ProdW'(vay_ff) * ProdW'(vay_ff);
         end
         ST_PREP4: begin
            outside_ff <= d2_ff > {1'b0, r2_ff};
            if (d2_ff > {1'b0, r2_ff}) begin
               z2_ff <= '0;
               m2_ff <= d2_ff;
            end else begin
               z2_ff <= r2_ff - d2_ff[Z2W-1:0];
               m2_ff <= {1'b0, r2_ff};
            end
         end
         ST_PREP5: begin
            nz2_ff <= ProdW'(vv_ff) * ProdW'(z2_ff);
         end
         default: begin
            nz2_ff <= nz2_ff;
         end
      endcase
   end

   // Capture roots; clear them first so a zero magnitude reports zeros
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP5) begin
         qx_ff <= '0;
         qy_ff <= '0;
         qz_ff <= '0;
      end else if ((state_ff == ST_SQRT) && sqrt_done) begin
         case (comp_ff)
            COMP_X:  qx_ff <= sqrt_root;
            COMP_Y:  qy_ff <= sqrt_root;
            default: qz_ff <= sqrt_root;
         endcase
      end
   end

   // Zero-extend the roots; signs are applied when the output register loads
   assign mag_x = {1'b0, qx_ff};
   assign mag_y = {1'b0, qy_ff};
   assign mag_z = {1'b0, qz_ff};

   // Output register: load a result, drop valid once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_index_ff   <= lane_ff;
         rsp_x_ff       <= negx_ff ? -mag_x : mag_x;
         rsp_y_ff       <= negy_ff ? -mag_y : mag_y;
         rsp_z_ff       <= mag_z;
         rsp_outside_ff <= outside_ff;
         rsp_last_ff    <= last_lane;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.image_index    = rsp_index_ff;
   assign rsp_ch.dir_x          = rsp_x_ff;
   assign rsp_ch.dir_y          = rsp_y_ff;
   assign rsp_ch.dir_z          = rsp_z_ff;
   assign rsp_ch.outside_sphere = rsp_outside_ff;
   assign rsp_ch.run_last       = rsp_last_ff;

endmodule
